FILE: design/xorshift_range_generator_top_assert.svh
// assertion macros for the xorshift range generator
`ifndef XORSHIFT_RANGE_GENERATOR_TOP_ASSERT_SVH
`define XORSHIFT_RANGE_GENERATOR_TOP_ASSERT_SVH

// condition holds in the same cycle
`define XRG_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define XRG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/xrg_pkg.sv
`timescale 1ns / 1ps

package xrg_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;
    localparam int unsigned STEP_W     = 5;

    localparam logic [REG_IDX_W-1:0] REG_SEED = '0;

    localparam logic [WORD_W-1:0] SEED_ZERO_SUBST = 32'd1022659036;

    typedef logic [3:0][WORD_W-1:0] words_t;

    localparam words_t DEFAULT_WORDS = {
        32'd1082589634, 32'd1881763598, 32'd1396960035, 32'd815279472
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic words_t seed_words(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] e;
        words_t w;
        e    = (s == '0) ? SEED_ZERO_SUBST : s;
        w[0] = e ^ (e << 11);
        w[1] = (e >> 9) ^ (w[0] >> 7);
        w[2] = (e << 3) ^ (w[1] >> 5);
        w[3] = (e >> 17) ^ (w[2] << 13);
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] next_word(input words_t w);
        logic [WORD_W-1:0] t;
        t = w[0] ^ (w[0] << 11);
        return (w[3] ^ (w[3] >> 13)) ^ (t ^ (t << 19));
    endfunction

endpackage

FILE: design/xrg_divider.sv
`timescale 1ns / 1ps

module xrg_divider
    import xrg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  div_ctrl_t         ctrl,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output div_stat_t         stat,
    output logic [WORD_W-1:0] remainder
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] count_reg, count_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [WORD_W-1:0] dsr_reg, dsr_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;

    // one remainder bit per cycle, restoring
    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        dsr_next   = dsr_reg;
        if (ctrl.start) begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            dvd_next   = dividend;
            dsr_next   = divisor;
        end else if (busy_reg) begin
            rem_next   = (trial >= {1'b0, dsr_reg}) ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            dvd_next   = dvd_reg << 1;
            count_next = count_reg + 1'b1;
            if (count_reg == '1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        count_reg <= count_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        dsr_reg   <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: design/xorshift_range_generator_top.sv
`timescale 1ns / 1ps
// each accepted item runs through ST_DIV, where the 32-step divider works, and then ST_DONE
// ST_DONE loads the output register once it is free, so a stalled result side holds the block
// the block takes no new item until its result sits in the output register
// reset: synchronous active-low, state words load the default words, seed reads zero
`include "xorshift_range_generator_top_assert.svh"

module xorshift_range_generator_top
    import xrg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [WORD_W-1:0]       pwdata,
    output logic [WORD_W-1:0]       prdata,
    output logic                    pready,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [WORD_W-1:0] s_range_min,
    input  logic signed [WORD_W-1:0] s_range_max,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [WORD_W-1:0]       m_raw_value,
    output logic signed [WORD_W-1:0] m_ranged_value,
    output logic                    m_span_was_zero
);

    state_t            state_reg, state_next;
    words_t            words_reg;
    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] raw_reg;
    logic [WORD_W-1:0] min_reg;
    logic              zero_reg;
    logic              m_valid_reg;
    logic [WORD_W-1:0] m_raw_reg;
    logic [WORD_W-1:0] m_ranged_reg;
    logic              m_zero_reg;

    logic              accept;
    logic              cfg_wr;
    logic              load_out;
    logic [WORD_W-1:0] raw_new;
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] rem;
    div_ctrl_t         div_ctrl;
    div_stat_t         div_stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready
                     && (paddr[APB_ADDR_W-1:2] == REG_SEED);
    assign prdata  = (paddr[APB_ADDR_W-1:2] == REG_SEED) ? seed_reg : '0;

    assign accept  = s_valid && s_ready;
    assign raw_new = next_word(words_reg);
    assign span    = WORD_W'($unsigned(s_range_max)) - WORD_W'($unsigned(s_range_min))
                     + WORD_W'(1);

    xrg_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .dividend  (raw_new),
        .divisor   (span),
        .stat      (div_stat),
        .remainder (rem)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        div_ctrl.start = 1'b0;
        load_out       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                div_ctrl.start = s_valid;
            end
            ST_DIV: begin
            end
            ST_DONE: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            words_reg   <= DEFAULT_WORDS;
            seed_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                seed_reg  <= pwdata;
                words_reg <= seed_words(pwdata);
            end else if (accept) begin
                words_reg <= {raw_new, words_reg[3], words_reg[2], words_reg[1]};
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            raw_reg  <= raw_new;
            min_reg  <= s_range_min;
            zero_reg <= (span == '0);
        end
        if (load_out) begin
            m_raw_reg    <= raw_reg;
            m_ranged_reg <= rem + min_reg;
            m_zero_reg   <= zero_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_raw_value     = m_raw_reg;
    assign m_ranged_value  = m_ranged_reg;
    assign m_span_was_zero = m_zero_reg;

    `XRG_ASSERT_IMPLY(a_ready_div_idle, aclk, aresetn, s_ready, !div_stat.busy,
        "item taken while divider busy")
    `XRG_ASSERT_NEXT(a_accept_starts_div, aclk, aresetn, accept,
        (state_reg == ST_DIV) && div_stat.busy, "accepted item did not start divider")
    `XRG_ASSERT_IMPLY(a_done_in_div, aclk, aresetn, div_stat.done, state_reg == ST_DIV,
        "divider finished outside divide state")
    `XRG_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn,
        (state_reg == ST_DONE) && m_valid_reg && !m_ready, state_reg == ST_DONE,
        "result dropped while output stalled")

endmodule

FILE: tb/sv/xrg_draw_checker.sv
`timescale 1ns / 1ps

module xrg_draw_checker
    import xrg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [WORD_W-1:0]        pwdata,
    input  logic [WORD_W-1:0]        prdata,
    input  logic                     pready,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic signed [WORD_W-1:0] s_range_min,
    input  logic signed [WORD_W-1:0] s_range_max,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [WORD_W-1:0]        m_raw_value,
    input  logic signed [WORD_W-1:0] m_ranged_value,
    input  logic                     m_span_was_zero,
    output int unsigned              fail_count,
    output int unsigned              pending
);

    typedef struct packed {
        logic [WORD_W-1:0] raw;
        logic [WORD_W-1:0] ranged;
        logic              full_span;
    } draw_t;

    logic [WORD_W-1:0] gen_w [4];
    logic [WORD_W-1:0] seed_shadow;
    draw_t             draw_q [$];

    // seed expansion into the four generator words
    function automatic void reseed_words(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] e;
        e = (seed == '0) ? SEED_ZERO_SUBST : seed;
        gen_w[0] = e ^ (e << 11);
        gen_w[1] = (e >> 9) ^ (gen_w[0] >> 7);
        gen_w[2] = (e << 3) ^ (gen_w[1] >> 5);
        gen_w[3] = (e >> 17) ^ (gen_w[2] << 13);
    endfunction

    function automatic draw_t draw_next(input logic [WORD_W-1:0] lo,
                                        input logic [WORD_W-1:0] hi);
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] span;
        draw_t d;
        t      = gen_w[0] ^ (gen_w[0] << 11);
        span   = hi - lo + 32'd1;
        d.raw  = (gen_w[3] ^ (gen_w[3] >> 13)) ^ (t ^ (t << 19));
        gen_w[0] = gen_w[1];
        gen_w[1] = gen_w[2];
        gen_w[2] = gen_w[3];
        gen_w[3] = d.raw;
        d.full_span = (span == '0);
        d.ranged    = d.full_span ? d.raw + lo : (d.raw % span) + lo;
        return d;
    endfunction

    task automatic note_fail(input string what, input logic [WORD_W-1:0] exp_v,
                             input logic [WORD_W-1:0] act_v);
        if (fail_count < 10) begin
            $display("%0t mismatch %s: expected %h got %h", $time, what, exp_v, act_v);
        end
        fail_count++;
    endtask

    always @(posedge aclk) begin
        draw_t d;
        if (!aresetn) begin
            foreach (gen_w[i]) gen_w[i] = DEFAULT_WORDS[i];
            seed_shadow = '0;
            draw_q.delete();
        end else begin
            if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_SEED) begin
                if (pwrite) begin
                    seed_shadow = pwdata;
                    reseed_words(pwdata);
                end else if (prdata !== seed_shadow) begin
                    note_fail("seed readback", seed_shadow, prdata);
                end
            end
            if (m_valid === 1'b1 && m_ready) begin
                if (draw_q.size() == 0) begin
                    note_fail("item with none pending", '0, m_raw_value);
                end else begin
                    d = draw_q.pop_front();
                    if (m_raw_value !== d.raw)
                        note_fail("raw_value", d.raw, m_raw_value);
                    if (m_ranged_value !== d.ranged)
                        note_fail("ranged_value", d.ranged, m_ranged_value);
                    if (m_span_was_zero !== d.full_span)
                        note_fail("span_was_zero", WORD_W'(d.full_span),
                                  WORD_W'(m_span_was_zero));
                end
            end
            if (s_valid && s_ready === 1'b1) begin
                draw_q.push_back(draw_next(s_range_min, s_range_max));
            end
        end
        pending = draw_q.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import xrg_pkg::*;

    localparam logic [REG_IDX_W-1:0]  REG_SPARE  = REG_SEED + 1'b1;
    localparam logic [APB_ADDR_W-1:0] SEED_ADDR  = {REG_SEED, 2'b00};
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {REG_SPARE, 2'b00};
    localparam int unsigned LATENCY      = 35;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_ITEMS  = 267;
    localparam int unsigned N_DIRECTED   = 18;

    localparam logic [WORD_W-1:0] DIR_LO [N_DIRECTED] = '{
        32'h8000_0000, 32'h0000_0000, 32'h0000_0005, 32'h0000_0000, 32'h7FFF_FFFF,
        32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h0000_000A, 32'hFFFF_FFF6, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
        32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555
    };
    localparam logic [WORD_W-1:0] DIR_HI [N_DIRECTED] = '{
        32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0004, 32'h0000_0000, 32'h7FFF_FFFF,
        32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
        32'hFFFF_FFF6, 32'h0000_000A, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000,
        32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
    };

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr = '0;
    logic [WORD_W-1:0]        pwdata = '0;
    logic [WORD_W-1:0]        prdata;
    logic                     pready;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [WORD_W-1:0] s_range_min = '0;
    logic signed [WORD_W-1:0] s_range_max = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [WORD_W-1:0]        m_raw_value;
    logic signed [WORD_W-1:0] m_ranged_value;
    logic                     m_span_was_zero;
    logic                     steady = 1'b0;
    int unsigned              fail_count;
    int unsigned              pending;

    xorshift_range_generator_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_range_min     (s_range_min),
        .s_range_max     (s_range_max),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_raw_value     (m_raw_value),
        .m_ranged_value  (m_ranged_value),
        .m_span_was_zero (m_span_was_zero)
    );

    xrg_draw_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_range_min     (s_range_min),
        .s_range_max     (s_range_max),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_raw_value     (m_raw_value),
        .m_ranged_value  (m_ranged_value),
        .m_span_was_zero (m_span_was_zero),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 28);
    end

    initial begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [WORD_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_range(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        while (!steady && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_range_min <= lo;
        s_range_max <= hi;
        do @(negedge aclk); while (s_ready !== 1'b1);
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    // mostly narrow or structured ranges, some full-span and arbitrary ones
    task automatic send_random_range();
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        int unsigned pick;
        pick = $urandom_range(9);
        lo   = $urandom;
        case (pick)
            0, 1, 2, 3: hi = lo + $urandom_range(255);
            4, 5:       hi = lo + ($urandom >> $urandom_range(31));
            6:          hi = lo - 32'd1;
            7:          hi = lo + (32'd1 << $urandom_range(31)) - 32'd1;
            default:    hi = $urandom;
        endcase
        send_range(lo, hi);
    endtask

    initial begin
        logic [WORD_W-1:0] phase_seed [PHASES];
        phase_seed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                       $urandom, $urandom};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset words and reset seed readback
        apb_xfer(1'b0, SEED_ADDR, '0);
        for (int i = 0; i < N_DIRECTED; i++) send_range(DIR_LO[i], DIR_HI[i]);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            if (p == 4) apb_xfer(1'b1, SPARE_ADDR, $urandom);
            apb_xfer(1'b1, SEED_ADDR, phase_seed[p]);
            apb_xfer(1'b0, SEED_ADDR, '0);
            steady = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 130) wait_drained();
                send_random_range();
            end
            wait_drained();
        end
        steady = 1'b0;

        repeat (LATENCY + 5) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
